// File: rtl/stff_pkg.sv
// ----------------------------------------------------------------------------
// stff_pkg
// Shared types and constants for the slot table with first-free allocation.
// ----------------------------------------------------------------------------
`default_nettype none

package stff_pkg;

  localparam int unsigned DEPTH_DEF       = 256;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_STORE  = 3'd1,
    ACT_LOOKUP = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_COUNT  = 3'd4,
    ACT_FIND   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  slot_index;
    logic [31:0] entry_value;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  result_index;
    logic [31:0] read_value;
    logic [8:0]  occupied_count;
  } result_t;

  // scan request from the sequencer
  typedef struct packed {
    logic start;
    logic down;
    logic invert;
    logic stop;
  } scan_cmd_t;

  // scan completion back to the sequencer
  typedef struct packed {
    logic done;
    logic hit;
  } scan_sts_t;

endpackage

`default_nettype wire

// File: rtl/stff_ram.sv
// ----------------------------------------------------------------------------
// stff_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/stff_scan.sv
// ----------------------------------------------------------------------------
// stff_scan
// Slot scanner: walks a range of slots one read per cycle and runs every
// value through a single compare unit, counting or stopping on a match.
// ----------------------------------------------------------------------------
`default_nettype none

module stff_scan #(
  parameter int unsigned DEPTH       = stff_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = stff_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire stff_pkg::scan_cmd_t    cmd_i,
  input  wire logic [CW-1:0]          first_i,
  input  wire logic [CW-1:0]          len_i,
  input  wire logic [VALUE_WIDTH-1:0] key_i,
  input  wire logic [VALUE_WIDTH-1:0] rdata_i,
  output logic      [AW-1:0]          raddr_o,
  output stff_pkg::scan_sts_t         sts_o,
  output logic      [CW-1:0]          pos_o,
  output logic      [CW-1:0]          cnt_o
);

  logic          active_q, active_d;
  logic          down_q, down_d;
  logic          inv_q, inv_d;
  logic          stop_q, stop_d;
  logic          chk_v_q, chk_v_d;
  logic [AW-1:0] chk_addr_q, chk_addr_d;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          match;
  logic          hit_now;
  logic          fin;
  logic          rd_en;

  assign match   = (rdata_i == key_i) ^ inv_q;
  assign hit_now = active_q && chk_v_q && match && stop_q;
  assign fin     = active_q && !chk_v_q && (left_q == '0);
  assign rd_en   = active_q && (left_q != '0) && !hit_now;
  assign raddr_o = pos_q[AW-1:0];

  assign sts_o.done = hit_now || fin;
  assign sts_o.hit  = hit_now;
  assign pos_o      = CW'(chk_addr_q);
  assign cnt_o      = cnt_q;

  always_comb begin
    active_d   = active_q;
    down_d     = down_q;
    inv_d      = inv_q;
    stop_d     = stop_q;
    chk_v_d    = chk_v_q;
    chk_addr_d = chk_addr_q;
    left_d     = left_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    if (cmd_i.start) begin
      active_d = 1'b1;
      down_d   = cmd_i.down;
      inv_d    = cmd_i.invert;
      stop_d   = cmd_i.stop;
      chk_v_d  = 1'b0;
      left_d   = len_i;
      pos_d    = first_i;
      cnt_d    = '0;
    end else if (active_q) begin
      if (sts_o.done) begin
        active_d = 1'b0;
        chk_v_d  = 1'b0;
      end else begin
        chk_v_d    = rd_en;
        chk_addr_d = pos_q[AW-1:0];
        if (rd_en) begin
          left_d = left_q - CW'(1);
          pos_d  = down_q ? (pos_q - CW'(1)) : (pos_q + CW'(1));
        end
        if (chk_v_q && match) begin
          cnt_d = cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      chk_v_q  <= 1'b0;
      left_q   <= '0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      chk_v_q  <= chk_v_d;
      left_q   <= left_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    down_q     <= down_d;
    inv_q      <= inv_d;
    stop_q     <= stop_d;
    chk_addr_q <= chk_addr_d;
    pos_q      <= pos_d;
  end

endmodule

`default_nettype wire

// File: rtl/slot_table_first_free.sv
// ----------------------------------------------------------------------------
// slot_table_first_free
// Fixed-size table of value slots (zero is empty) with a high-water mark:
// insert first free, store, lookup, clear, count and find.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table to zero, one slot a cycle, and holds
// busy high until the last slot is written. An item is taken when start is
// high and busy is low; its result shows on result_o with done_o high for one
// cycle, and the receiver cannot stall it. Store, lookup, unused actions and
// clears not of the topmost slot finish in the execute state, an in-range
// lookup via a read state. Insert, count and find walk the slots below the
// mark through the one-read-per-cycle RAM port and a single comparator,
// insert and find stopping on a match; clearing the topmost slot walks down.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_table_first_free #(
  parameter int unsigned DEPTH       = stff_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = stff_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire stff_pkg::item_t  item_i,
  output logic                  busy,
  output logic                  done_o,
  output stff_pkg::result_t     result_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (CW > 9) ? CW : 9;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned EW = VW + 32;
  localparam int unsigned XW = CW + 8;
  localparam int unsigned NW = CW + 9;

  stff_pkg::state_e  state_q, state_d;
  stff_pkg::action_e act_q;
  logic [IW-1:0]     idx_q;
  logic [VW-1:0]     val_q;
  logic [CW-1:0]     hw_q, hw_d;
  logic [AW-1:0]     wipe_q, wipe_d;
  logic              done_q, done_d;
  stff_pkg::result_t res_q, res_d;

  logic              accept;
  logic              oor;
  logic              at_top;
  logic [AW-1:0]     idx_a;
  logic [CW-1:0]     idx_c;
  logic [EW-1:0]     val_ext;
  logic [EW-1:0]     rd_ext;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [VW-1:0]     ram_rdata;

  stff_pkg::scan_cmd_t scan_cmd;
  stff_pkg::scan_sts_t scan_sts;
  logic [CW-1:0]       scan_first;
  logic [CW-1:0]       scan_len;
  logic [VW-1:0]       scan_key;
  logic [AW-1:0]       scan_raddr;
  logic [CW-1:0]       scan_pos;
  logic [CW-1:0]       scan_cnt;

  logic [CW-1:0]     ins_pos;
  logic              ins_full;
  logic [XW-1:0]     ridx_ext;
  logic [NW-1:0]     cnt_ext;

  assign accept  = start && !busy;
  assign busy    = (state_q != stff_pkg::S_IDLE);
  assign done_o  = done_q;
  assign result_o = res_q;

  assign val_ext = EW'(item_i.entry_value);
  assign oor     = (idx_q >= IW'(DEPTH));
  assign at_top  = ((idx_q + IW'(1)) == IW'(hw_q));
  assign idx_a   = idx_q[AW-1:0];
  assign idx_c   = idx_q[CW-1:0];
  assign rd_ext  = EW'(ram_rdata);

  assign scan_first = (act_q == stff_pkg::ACT_CLEAR) ? (idx_c - CW'(1)) : '0;
  assign scan_len   = (act_q == stff_pkg::ACT_CLEAR) ? idx_c : hw_q;
  assign scan_key   = (act_q == stff_pkg::ACT_FIND) ? val_q : '0;

  assign ins_pos  = scan_sts.hit ? scan_pos : hw_q;
  assign ins_full = !scan_sts.hit && (hw_q == CW'(DEPTH));
  assign cnt_ext  = NW'(scan_cnt);

  stff_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stff_scan #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (scan_cmd),
    .first_i (scan_first),
    .len_i   (scan_len),
    .key_i   (scan_key),
    .rdata_i (ram_rdata),
    .raddr_o (scan_raddr),
    .sts_o   (scan_sts),
    .pos_o   (scan_pos),
    .cnt_o   (scan_cnt)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stff_pkg::S_WIPE: begin
        if (wipe_q == AW'(DEPTH - 1)) begin
          state_d = stff_pkg::S_IDLE;
        end
      end
      stff_pkg::S_IDLE: begin
        if (start) begin
          state_d = stff_pkg::S_EXEC;
        end
      end
      stff_pkg::S_EXEC: begin
        case (act_q)
          stff_pkg::ACT_INSERT, stff_pkg::ACT_COUNT, stff_pkg::ACT_FIND: begin
            state_d = stff_pkg::S_SCAN;
          end
          stff_pkg::ACT_LOOKUP: begin
            state_d = oor ? stff_pkg::S_IDLE : stff_pkg::S_READ;
          end
          stff_pkg::ACT_CLEAR: begin
            state_d = (!oor && at_top) ? stff_pkg::S_SCAN : stff_pkg::S_IDLE;
          end
          default: begin
            state_d = stff_pkg::S_IDLE;
          end
        endcase
      end
      stff_pkg::S_READ: begin
        state_d = stff_pkg::S_IDLE;
      end
      stff_pkg::S_SCAN: begin
        if (scan_sts.done) begin
          state_d = stff_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = stff_pkg::S_IDLE;
      end
    endcase
  end

  // datapath control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_a;
    ram_wdata = '0;
    ram_raddr = scan_raddr;
    scan_cmd  = '0;
    hw_d      = hw_q;
    wipe_d    = wipe_q;
    done_d    = 1'b0;
    res_d     = '0;
    ridx_ext  = '0;
    unique case (state_q)
      stff_pkg::S_WIPE: begin
        ram_we    = 1'b1;
        ram_waddr = wipe_q;
        wipe_d    = wipe_q + AW'(1);
      end
      stff_pkg::S_IDLE: begin
      end
      stff_pkg::S_EXEC: begin
        case (act_q)
          stff_pkg::ACT_INSERT: begin
            scan_cmd.start = 1'b1;
            scan_cmd.stop  = 1'b1;
          end
          stff_pkg::ACT_STORE: begin
            done_d = 1'b1;
            if (oor) begin
              res_d.status = stff_pkg::STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = val_q;
              if (hw_q <= idx_c) begin
                hw_d = idx_c + CW'(1);
              end
              ridx_ext           = XW'(idx_c);
              res_d.result_index = ridx_ext[7:0];
            end
          end
          stff_pkg::ACT_LOOKUP: begin
            ram_raddr = idx_a;
            if (oor) begin
              done_d       = 1'b1;
              res_d.status = stff_pkg::STAT_FULL;
            end
          end
          stff_pkg::ACT_CLEAR: begin
            if (oor) begin
              done_d       = 1'b1;
              res_d.status = stff_pkg::STAT_FULL;
            end else begin
              ram_we = 1'b1;
              if (at_top) begin
                scan_cmd.start  = 1'b1;
                scan_cmd.down   = 1'b1;
                scan_cmd.invert = 1'b1;
                scan_cmd.stop   = 1'b1;
              end else begin
                done_d = 1'b1;
              end
            end
          end
          stff_pkg::ACT_COUNT: begin
            scan_cmd.start  = 1'b1;
            scan_cmd.invert = 1'b1;
          end
          stff_pkg::ACT_FIND: begin
            scan_cmd.start = 1'b1;
            scan_cmd.stop  = 1'b1;
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end
      stff_pkg::S_READ: begin
        done_d           = 1'b1;
        res_d.read_value = rd_ext[31:0];
      end
      stff_pkg::S_SCAN: begin
        if (scan_sts.done) begin
          done_d = 1'b1;
          case (act_q)
            stff_pkg::ACT_INSERT: begin
              if (ins_full) begin
                res_d.status = stff_pkg::STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ins_pos[AW-1:0];
                ram_wdata = val_q;
                if (hw_q <= ins_pos) begin
                  hw_d = ins_pos + CW'(1);
                end
                ridx_ext           = XW'(ins_pos);
                res_d.result_index = ridx_ext[7:0];
              end
            end
            stff_pkg::ACT_CLEAR: begin
              hw_d = scan_sts.hit ? (scan_pos + CW'(1)) : '0;
            end
            stff_pkg::ACT_COUNT: begin
              res_d.occupied_count = cnt_ext[8:0];
            end
            stff_pkg::ACT_FIND: begin
              if (scan_sts.hit) begin
                ridx_ext           = XW'(scan_pos);
                res_d.result_index = ridx_ext[7:0];
              end else begin
                res_d.status = stff_pkg::STAT_MISS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stff_pkg::S_WIPE;
      hw_q    <= '0;
      wipe_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hw_q    <= hw_d;
      wipe_q  <= wipe_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= stff_pkg::action_e'(item_i.action);
      idx_q <= IW'(item_i.slot_index);
      val_q <= val_ext[VW-1:0];
    end
    if (done_d) begin
      res_q <= res_d;
    end
  end

  // a result only follows busy cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result strobe without work in progress");

  // a transfer always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("accepted transfer did not raise busy");

  // one result per transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // mark never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni) hw_q <= CW'(DEPTH))
    else $error("high-water mark beyond table depth");

endmodule

`default_nettype wire
